### hw/rtl/sbrd_pkg.sv
// ----------------------------------------------------------------------------
// Smart beacon report decider package
// Shared types, widths, register indexes and the circular turn test.
// ----------------------------------------------------------------------------
package sbrd_pkg;

	// Field widths.
	localparam int TIME_W   = 22;
	localparam int SPEED_W  = 12;
	localparam int COURSE_W = 9;
	localparam int DIST_W   = 20;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Serial period unit widths.
	localparam int PROD_W  = DIST_W + BYTE_W;   // distance times period
	localparam int MULT_W  = 12;                // scaled pause and distance factors
	localparam int ACC_W   = 41;                // holds every product and sum
	localparam int CNT_W   = 4;

	// Receiver course is trusted above this speed (tenths of a knot).
	localparam logic [SPEED_W-1:0] COURSE_MIN_SPEED = 12'd10;
	localparam logic [BYTE_W-1:0]  PAUSE_SAT        = 8'd255;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TURN_LIMIT = 3'd0,
		REG_MIN_PAUSE  = 3'd1,
		REG_MAX_PAUSE  = 3'd2,
		REG_MIN_DIST   = 3'd3,
		REG_PERIOD     = 3'd4,
		REG_EXTRA_TURN = 3'd5,
		REG_STOP_SPEED = 3'd6,
		REG_MOVE_SPEED = 3'd7
	} cfg_reg_t;

	// Top level sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} ctrl_state_t;

	// Serial period unit phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PROD,
		PH_MUL,
		PH_ADD,
		PH_CMP
	} phase_t;

	// Operands for the period comparison:
	// m_lhs * dist * sl  >  m_pause * dist * sl + m_dist * el
	typedef struct packed {
		logic                  start;
		logic [DIST_W-1:0]     dist_eff;
		logic [BYTE_W-1:0]     sl;
		logic [TIME_W-1:0]     el;
		logic [MULT_W-1:0]     m_lhs;
		logic [MULT_W-1:0]     m_pause;
		logic [MULT_W-1:0]     m_dist;
	} period_req_t;

	typedef struct packed {
		logic done;
		logic gt;
	} period_rsp_t;

	// Circular course change test: |d| > L and min(|d-360|, |d+360|) > L.
	function automatic logic turned(logic [COURSE_W-1:0] a, logic [COURSE_W-1:0] b,
			logic [COURSE_W-1:0] limit);
		logic signed [10:0] d;
		logic signed [10:0] dm;
		logic signed [10:0] dp;
		logic [10:0] ad;
		logic [10:0] adm;
		logic [10:0] adp;
		logic [10:0] mn;
		logic [10:0] lim;
		d   = $signed({2'b00, a}) - $signed({2'b00, b});
		dm  = d - 11'sd360;
		dp  = d + 11'sd360;
		ad  = d[10]  ? 11'(-d)  : 11'(d);
		adm = dm[10] ? 11'(-dm) : 11'(dm);
		adp = dp[10] ? 11'(-dp) : 11'(dp);
		mn  = (adm < adp) ? adm : adp;
		lim = {2'b00, limit};
		return (ad > lim) && (mn > lim);
	endfunction

endpackage

### hw/rtl/sbrd_period_unit.sv
// ----------------------------------------------------------------------------
// Serial period comparator
// Works out the speed-scaled period test with shift-and-add multiplication,
// one multiplier bit per cycle, then a single final compare.
// ----------------------------------------------------------------------------
module sbrd_period_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbrd_pkg::period_req_t req,
	output sbrd_pkg::period_rsp_t rsp
);
	import sbrd_pkg::*;

	phase_t            phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  mcand_q;
	logic [BYTE_W-1:0] sl_q;
	logic [MULT_W-1:0] m_lhs_q;
	logic [MULT_W-1:0] m_pause_q;
	logic [MULT_W-1:0] m_dist_q;
	logic [TIME_W-1:0] el_q;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  lhs_q;
	logic [ACC_W-1:0]  rhs_q;
	logic              gt_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_next;

	// Distance times period, one period bit per cycle.
	assign prod_next = prod_q + (sl_q[0] ? mcand_q[PROD_W-1:0] : '0);

	// Phase sequencing and the shift-and-add datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_CMP);
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_PROD;
						cnt_q   <= '0;
					end
				end
				PH_PROD: begin
					if (cnt_q == CNT_W'(BYTE_W - 1)) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_MUL: begin
					if (cnt_q == CNT_W'(MULT_W - 1)) begin
						phase_q <= PH_ADD;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_ADD: begin
					if (cnt_q == CNT_W'(MULT_W - 1)) begin
						phase_q <= PH_CMP;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_CMP: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Operand shift registers and accumulators.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					mcand_q   <= ACC_W'(req.dist_eff);
					sl_q      <= req.sl;
					el_q      <= req.el;
					m_lhs_q   <= req.m_lhs;
					m_pause_q <= req.m_pause;
					m_dist_q  <= req.m_dist;
					prod_q    <= '0;
					lhs_q     <= '0;
					rhs_q     <= '0;
				end
			end
			PH_PROD: begin
				prod_q <= prod_next;
				sl_q   <= sl_q >> 1;
				if (cnt_q == CNT_W'(BYTE_W - 1)) begin
					mcand_q <= ACC_W'(prod_next);
				end else begin
					mcand_q <= mcand_q << 1;
				end
			end
			PH_MUL: begin
				lhs_q     <= lhs_q + (m_lhs_q[0] ? mcand_q : '0);
				rhs_q     <= rhs_q + (m_pause_q[0] ? mcand_q : '0);
				m_lhs_q   <= m_lhs_q >> 1;
				m_pause_q <= m_pause_q >> 1;
				if (cnt_q == CNT_W'(MULT_W - 1)) begin
					mcand_q <= ACC_W'(el_q);
				end else begin
					mcand_q <= mcand_q << 1;
				end
			end
			PH_ADD: begin
				rhs_q    <= rhs_q + (m_dist_q[0] ? mcand_q : '0);
				m_dist_q <= m_dist_q >> 1;
				mcand_q  <= mcand_q << 1;
			end
			PH_CMP: begin
				gt_q <= lhs_q > rhs_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.gt   = gt_q;

endmodule

### hw/rtl/smart_beacon_report_decider.sv
// Each accepted input word runs through the serial period unit, which first
// forms distance times period and then the scaled products; the next word is
// accepted only once the result has been loaded into the output register.
// A finished result waits in the output register while the next word enters.
// Reset (arst_n, asynchronous) loads the default register values and clears
// the tracking state; the previous fix then counts as reported.
// ----------------------------------------------------------------------------
// Smart beacon report decider
// Decides per GPS fix whether a position report is due, using turn, pause,
// timeout, speed-crossing, distance and speed-scaled period triggers.
// ----------------------------------------------------------------------------
module smart_beacon_report_decider (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Fix input channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sbrd_pkg::TIME_W-1:0]       fix_time_s,
	input  logic [sbrd_pkg::SPEED_W-1:0]      speed_tenths,
	input  logic [sbrd_pkg::COURSE_W-1:0]     gps_course_deg,
	input  logic [sbrd_pkg::COURSE_W-1:0]     bearing_deg,
	input  logic [sbrd_pkg::DIST_W-1:0]       distance_m,
	input  logic                              fix_wait_timeout,
	// Decision output channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              send_report,
	output logic                              save_previous_fix,
	output logic                              max_pause_hit,
	output logic [sbrd_pkg::COURSE_W-1:0]     report_course_deg
);
	import sbrd_pkg::*;

	// Configuration registers.
	logic [COURSE_W-1:0] turn_limit_q;
	logic [BYTE_W-1:0]   min_pause_q;
	logic [BYTE_W-1:0]   max_pause_q;
	logic [BYTE_W-1:0]   min_dist_q;
	logic [BYTE_W-1:0]   period_q;
	logic                extra_turn_q;
	logic [SPEED_W-1:0]  stop_speed_q;
	logic [SPEED_W-1:0]  move_speed_q;

	// Tracking state.
	logic [BYTE_W-1:0]   pause_cnt_q;
	logic [COURSE_W-1:0] cur_course_q;
	logic                cur_course_vld_q;
	logic [COURSE_W-1:0] rep_course_q;
	logic                rep_course_vld_q;
	logic [TIME_W-1:0]   rep_time_q;
	logic [SPEED_W-1:0]  rep_speed_q;
	logic                have_rep_q;
	logic                prev_rep_q;

	// Per-fix decisions held while the period unit runs.
	logic                turn_q;
	logic                save_q;
	logic                maxhit_q;
	logic                other_q;
	logic                moving_q;
	logic                sat_q;
	logic [COURSE_W-1:0] course_q;
	logic [BYTE_W-1:0]   pc_inc_q;
	logic [TIME_W-1:0]   time_q;
	logic [SPEED_W-1:0]  speed_q;

	// Output register.
	logic                out_valid_q;
	logic                send_q;
	logic                save_out_q;
	logic                maxhit_out_q;
	logic [COURSE_W-1:0] course_out_q;

	ctrl_state_t         state_q;
	ctrl_state_t         state_d;

	logic                in_acc;
	logic                fin_load;
	logic                send_c;
	period_req_t         preq;
	period_rsp_t         prsp;

	// Front-end decode of the incoming word.
	logic [BYTE_W-1:0]   pc_inc;
	logic [COURSE_W-1:0] course;
	logic [DIST_W-1:0]   dist_eff;
	logic [TIME_W-1:0]   el;
	logic                fast;
	logic                slow;
	logic                moving;
	logic                paused;
	logic                maxhit;
	logic                turn_c;
	logic                save_c;
	logic                speed_cross;
	logic                far_c;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		pc_inc = (pause_cnt_q == PAUSE_SAT) ? pause_cnt_q : pause_cnt_q + 1'b1;
		maxhit = pc_inc >= max_pause_q;
		paused = pc_inc >= min_pause_q;
		course = (speed_tenths > COURSE_MIN_SPEED) ? gps_course_deg : bearing_deg;
		dist_eff = have_rep_q ? distance_m : '0;
		el     = (fix_time_s < rep_time_q) ? fix_time_s : fix_time_s - rep_time_q;
		fast   = (el != '0) && ((24'(dist_eff) * 24'd5) > (24'(el) << 2));
		slow   = (el == '0) || (TIME_W'(dist_eff) <= el);
		moving = (el != '0) && (dist_eff != '0);
		turn_c = fast && rep_course_vld_q && turned(course, rep_course_q, turn_limit_q);
		save_c = extra_turn_q && !prev_rep_q && cur_course_vld_q &&
			turned(course, cur_course_q, turn_limit_q >> 1);
		speed_cross = paused &&
			((speed_tenths < stop_speed_q && rep_speed_q > move_speed_q) ||
			 (rep_speed_q < stop_speed_q && speed_tenths > move_speed_q));
		far_c  = paused && slow && (dist_eff >= DIST_W'(min_dist_q));
	end

	// Operands for the serial period test.
	always_comb begin
		preq.start    = in_acc;
		preq.dist_eff = dist_eff;
		preq.sl       = (period_q == '0) ? BYTE_W'(1) : period_q;
		preq.el       = el;
		preq.m_lhs    = MULT_W'(({4'd0, pc_inc} + 12'd1) * 12'd10);
		preq.m_pause  = MULT_W'({4'd0, min_pause_q} * 12'd14);
		preq.m_dist   = MULT_W'({4'd0, min_dist_q} * 12'd10);
	end

	sbrd_period_unit u_period (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.rsp    (prsp)
	);

	// Sequencer: accept, run the period unit, then hand over the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (prsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Final decision: a report is sent when any trigger fires.
	assign send_c = turn_q || other_q || (moving_q && (sat_q || prsp.gt));

	// Capture the front-end decisions on acceptance.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			turn_q   <= turn_c;
			save_q   <= turn_c && save_c;
			maxhit_q <= maxhit;
			other_q  <= maxhit || fix_wait_timeout || speed_cross || far_c;
			moving_q <= moving;
			sat_q    <= pc_inc == PAUSE_SAT;
			course_q <= course;
			pc_inc_q <= pc_inc;
			time_q   <= fix_time_s;
			speed_q  <= speed_tenths;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_limit_q <= 9'd30;
			min_pause_q  <= 8'd2;
			max_pause_q  <= 8'd10;
			min_dist_q   <= 8'd100;
			period_q     <= 8'd10;
			extra_turn_q <= 1'b0;
			stop_speed_q <= 12'd16;
			move_speed_q <= 12'd81;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TURN_LIMIT: turn_limit_q <= cfg_data[COURSE_W-1:0];
				REG_MIN_PAUSE:  min_pause_q  <= cfg_data[BYTE_W-1:0];
				REG_MAX_PAUSE:  max_pause_q  <= cfg_data[BYTE_W-1:0];
				REG_MIN_DIST:   min_dist_q   <= cfg_data[BYTE_W-1:0];
				REG_PERIOD:     period_q     <= cfg_data[BYTE_W-1:0];
				REG_EXTRA_TURN: extra_turn_q <= cfg_data[0];
				REG_STOP_SPEED: stop_speed_q <= cfg_data[SPEED_W-1:0];
				REG_MOVE_SPEED: move_speed_q <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Tracking state is committed when the result is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_cnt_q      <= '0;
			cur_course_q     <= '0;
			cur_course_vld_q <= 1'b0;
			rep_course_q     <= '0;
			rep_course_vld_q <= 1'b0;
			rep_time_q       <= '0;
			rep_speed_q      <= '0;
			have_rep_q       <= 1'b0;
			prev_rep_q       <= 1'b1;
		end else if (fin_load) begin
			pause_cnt_q      <= send_c ? '0 : pc_inc_q;
			cur_course_q     <= course_q;
			cur_course_vld_q <= 1'b1;
			prev_rep_q       <= send_c;
			if (send_c) begin
				rep_course_q     <= course_q;
				rep_course_vld_q <= 1'b1;
				rep_time_q       <= time_q;
				rep_speed_q      <= speed_q;
				have_rep_q       <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			send_q       <= send_c;
			save_out_q   <= save_q;
			maxhit_out_q <= maxhit_q;
			course_out_q <= course_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign send_report       = send_q;
	assign save_previous_fix = save_out_q;
	assign max_pause_hit     = maxhit_out_q;
	assign report_course_deg = course_out_q;

endmodule
